// ===== rtl/histogram_peak_range_picker_assert.svh =====
// Assertion macros shared by the histogram peak range picker RTL.
`ifndef HISTOGRAM_PEAK_RANGE_PICKER_ASSERT_SVH
`define HISTOGRAM_PEAK_RANGE_PICKER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HPPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HPPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hppr_pkg.sv =====
// Shared constants, types and band tables of the histogram peak range picker.
package hppr_pkg;

    localparam int COUNT_BITS   = 20;
    localparam int COL_BITS     = 11;
    localparam int BIN_BITS     = 8;
    localparam int NUM_BINS     = 1 << BIN_BITS;
    localparam int SUM_BITS     = COUNT_BITS + 7;
    localparam int JUDGE_BITS   = SUM_BITS + 5;
    localparam int THR_BITS     = COUNT_BITS + 5;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] REG_CROP_COL_LOW  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_CROP_COL_HIGH = CFG_IDX_BITS'(1);

    localparam logic [COL_BITS-1:0] CROP_COL_LOW_RESET  = COL_BITS'(150);
    localparam logic [COL_BITS-1:0] CROP_COL_HIGH_RESET = COL_BITS'(489);

    localparam logic [BIN_BITS-1:0] BIN_LAST = BIN_BITS'(255);
    localparam logic [BIN_BITS-1:0] UP_END   = BIN_BITS'(255);
    localparam logic [BIN_BITS-1:0] DOWN_END = BIN_BITS'(1);

    localparam int PEAK_DIV       = 20;
    localparam int KEPT_DIV_HIGH  = 10;
    localparam int KEPT_DIV_MID   = 20;
    localparam int THR_DIV        = 10;
    localparam int MISS_LIMIT     = 3;

    typedef enum logic [1:0] {
        BAND_HIGH,
        BAND_MID,
        BAND_LOW
    } band_t;

    // Command from the scan sequencer to the histogram memory.
    typedef struct packed {
        logic                rd_en;
        logic                clr_en;
        logic [BIN_BITS-1:0] addr;
    } mem_cmd_t;

    function automatic logic [BIN_BITS-1:0] band_top(input band_t band);
        logic [BIN_BITS-1:0] result;
        unique case (band)
            BAND_HIGH: result = BIN_BITS'(255);
            BAND_MID:  result = BIN_BITS'(200);
            BAND_LOW:  result = BIN_BITS'(100);
            default:   result = BIN_BITS'(100);
        endcase
        return result;
    endfunction

    function automatic logic [BIN_BITS-1:0] band_bottom(input band_t band);
        logic [BIN_BITS-1:0] result;
        unique case (band)
            BAND_HIGH: result = BIN_BITS'(201);
            BAND_MID:  result = BIN_BITS'(101);
            BAND_LOW:  result = BIN_BITS'(51);
            default:   result = BIN_BITS'(51);
        endcase
        return result;
    endfunction

endpackage

// ===== rtl/hppr_hist.sv =====
// Histogram memory with the read-modify-write counting pipeline and the kept-pixel counter.
module hppr_hist
    import hppr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  acc_en,
    input  logic [BIN_BITS-1:0]   acc_bin,
    input  mem_cmd_t              cmd,
    output logic [COUNT_BITS-1:0] rd_data,
    output logic [COUNT_BITS-1:0] kept_count
);

    logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  s1_valid_reg;
    logic [BIN_BITS-1:0]   s1_bin_reg;
    logic                  fwd_valid_reg;
    logic [BIN_BITS-1:0]   fwd_bin_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] kept_reg;

    logic [BIN_BITS-1:0]   rd_addr;
    logic [COUNT_BITS-1:0] count_cur;
    logic [COUNT_BITS-1:0] count_next;
    logic                  wr_en;
    logic [BIN_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign rd_addr = cmd.rd_en ? cmd.addr : acc_bin;

    // The read for an item happens at the edge where the item before it writes,
    // so that write is forwarded here.
    assign count_cur  = (fwd_valid_reg && (fwd_bin_reg == s1_bin_reg)) ? fwd_data_reg
                                                                        : rd_data_reg;
    assign count_next = (count_cur == COUNT_MAX) ? count_cur : count_cur + COUNT_BITS'(1);

    assign wr_en   = s1_valid_reg || cmd.clr_en;
    assign wr_addr = cmd.clr_en ? cmd.addr : s1_bin_reg;
    assign wr_data = cmd.clr_en ? '0 : count_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bin_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_bin_reg    <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_bin_reg   <= '0;
            fwd_data_reg  <= '0;
            kept_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= acc_en;
            s1_bin_reg    <= acc_bin;
            fwd_valid_reg <= s1_valid_reg;
            fwd_bin_reg   <= s1_bin_reg;
            fwd_data_reg  <= count_next;
            if (cmd.clr_en)
            begin
                kept_reg <= '0;
            end
            else if (acc_en && (kept_reg != COUNT_MAX))
            begin
                kept_reg <= kept_reg + COUNT_BITS'(1);
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign kept_count = kept_reg;

endmodule

// ===== rtl/hppr_scan.sv =====
// Frame-end sequencer: band peak search, range widening, result register and clearing sweep.
module hppr_scan
    import hppr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] rd_data,
    input  logic [COUNT_BITS-1:0] kept_count,
    output mem_cmd_t              cmd,
    output logic                  idle,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BIN_BITS-1:0]   peak_value,
    output logic [BIN_BITS-1:0]   range_low,
    output logic [BIN_BITS-1:0]   range_high,
    output logic                  range_ok
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_BAND,
        S_JUDGE,
        S_UP,
        S_DOWN,
        S_EMIT,
        S_CLEAR
    } state_t;

    state_t                state_reg;
    band_t                 band_reg;
    logic [BIN_BITS-1:0]   addr_reg;
    logic [BIN_BITS-1:0]   end_reg;
    logic                  issue_on_reg;
    logic                  ret_valid_reg;
    logic [BIN_BITS-1:0]   ret_idx_reg;
    logic                  ret_last_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [COUNT_BITS-1:0] best_reg;
    logic [BIN_BITS-1:0]   idx_reg;
    logic [BIN_BITS-1:0]   peak_reg;
    logic [COUNT_BITS-1:0] peak_cnt_reg;
    logic [2:0]            misses_reg;
    logic [BIN_BITS-1:0]   upper_reg;
    logic [BIN_BITS-1:0]   lower_reg;
    logic                  out_valid_reg;
    logic [BIN_BITS-1:0]   peak_out_reg;
    logic [BIN_BITS-1:0]   low_out_reg;
    logic [BIN_BITS-1:0]   high_out_reg;
    logic                  ok_out_reg;

    logic                  sweeping;
    logic                  rd_en;
    logic                  miss;
    logic [2:0]            misses_next;
    logic                  stop_now;
    logic [BIN_BITS-1:0]   addr_step;
    logic [SUM_BITS-1:0]   sum_next;
    logic [JUDGE_BITS-1:0] kept_div;
    logic                  weak_band;
    logic                  slot_free;

    always_comb
    begin
        sweeping    = (state_reg == S_BAND) || (state_reg == S_UP) || (state_reg == S_DOWN);
        // A bin is weak when it lies below a tenth of the peak count.
        miss        = THR_BITS'(peak_cnt_reg) >=
                      (THR_BITS'(rd_data) + THR_BITS'(1)) * THR_BITS'(THR_DIV);
        misses_next = misses_reg + 3'(miss);
        stop_now    = ((state_reg == S_UP) || (state_reg == S_DOWN)) && ret_valid_reg &&
                      ((misses_next > 3'(MISS_LIMIT)) || ret_last_reg);
        rd_en       = sweeping && issue_on_reg && !stop_now;
        addr_step   = (state_reg == S_UP) ? addr_reg + BIN_BITS'(1)
                                          : addr_reg - BIN_BITS'(1);
        sum_next    = sum_reg + SUM_BITS'(rd_data);
        kept_div    = (band_reg == BAND_HIGH) ? JUDGE_BITS'(KEPT_DIV_HIGH)
                                              : JUDGE_BITS'(KEPT_DIV_MID);
        // Floor divisions rewritten as products: best < sum/20 and sum < kept/k.
        weak_band   = (JUDGE_BITS'(sum_reg) >=
                       (JUDGE_BITS'(best_reg) + JUDGE_BITS'(1)) * JUDGE_BITS'(PEAK_DIV)) ||
                      (JUDGE_BITS'(kept_count) >=
                       (JUDGE_BITS'(sum_reg) + JUDGE_BITS'(1)) * kept_div);
        slot_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            band_reg      <= BAND_HIGH;
            addr_reg      <= '0;
            end_reg       <= '0;
            issue_on_reg  <= 1'b0;
            ret_valid_reg <= 1'b0;
            ret_idx_reg   <= '0;
            ret_last_reg  <= 1'b0;
            sum_reg       <= '0;
            best_reg      <= '0;
            idx_reg       <= '0;
            peak_reg      <= '0;
            peak_cnt_reg  <= '0;
            misses_reg    <= '0;
            upper_reg     <= '0;
            lower_reg     <= '0;
            out_valid_reg <= 1'b0;
            peak_out_reg  <= '0;
            low_out_reg   <= '0;
            high_out_reg  <= '0;
            ok_out_reg    <= 1'b0;
        end
        else
        begin
            ret_valid_reg <= rd_en;
            if (rd_en)
            begin
                addr_reg     <= addr_step;
                ret_idx_reg  <= addr_reg;
                ret_last_reg <= (addr_reg == end_reg);
                if (addr_reg == end_reg)
                begin
                    issue_on_reg <= 1'b0;
                end
            end

            // The emit state reloads the output register on its own.
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // The frame's last count lands in memory during this cycle.
                    band_reg     <= BAND_HIGH;
                    addr_reg     <= band_top(BAND_HIGH);
                    end_reg      <= band_bottom(BAND_HIGH);
                    issue_on_reg <= 1'b1;
                    sum_reg      <= '0;
                    best_reg     <= '0;
                    idx_reg      <= band_top(BAND_HIGH);
                    state_reg    <= S_BAND;
                end
                S_BAND:
                begin
                    if (ret_valid_reg)
                    begin
                        sum_reg <= sum_next;
                        if (rd_data > best_reg)
                        begin
                            best_reg <= rd_data;
                            idx_reg  <= ret_idx_reg;
                        end
                        if (ret_last_reg)
                        begin
                            state_reg <= S_JUDGE;
                        end
                    end
                end
                S_JUDGE:
                begin
                    if ((band_reg != BAND_LOW) && weak_band)
                    begin
                        band_reg     <= band_t'(band_reg + 2'd1);
                        addr_reg     <= band_top(band_t'(band_reg + 2'd1));
                        end_reg      <= band_bottom(band_t'(band_reg + 2'd1));
                        issue_on_reg <= 1'b1;
                        sum_reg      <= '0;
                        best_reg     <= '0;
                        idx_reg      <= band_top(band_t'(band_reg + 2'd1));
                        state_reg    <= S_BAND;
                    end
                    else
                    begin
                        peak_reg     <= idx_reg;
                        peak_cnt_reg <= best_reg;
                        upper_reg    <= idx_reg;
                        lower_reg    <= idx_reg;
                        misses_reg   <= '0;
                        addr_reg     <= idx_reg;
                        end_reg      <= UP_END;
                        issue_on_reg <= 1'b1;
                        state_reg    <= S_UP;
                    end
                end
                S_UP:
                begin
                    if (ret_valid_reg && !miss)
                    begin
                        upper_reg <= ret_idx_reg;
                    end
                    if (stop_now)
                    begin
                        misses_reg   <= '0;
                        addr_reg     <= peak_reg;
                        end_reg      <= DOWN_END;
                        issue_on_reg <= 1'b1;
                        state_reg    <= S_DOWN;
                    end
                    else if (ret_valid_reg)
                    begin
                        misses_reg <= misses_next;
                    end
                end
                S_DOWN:
                begin
                    if (ret_valid_reg)
                    begin
                        misses_reg <= misses_next;
                        if (!miss)
                        begin
                            lower_reg <= ret_idx_reg;
                        end
                    end
                    if (stop_now)
                    begin
                        issue_on_reg <= 1'b0;
                        state_reg    <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        peak_out_reg  <= peak_reg;
                        low_out_reg   <= lower_reg;
                        high_out_reg  <= upper_reg;
                        ok_out_reg    <= (upper_reg != lower_reg) && (upper_reg != peak_reg);
                        addr_reg      <= '0;
                        state_reg     <= S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + BIN_BITS'(1);
                    if (addr_reg == BIN_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    assign cmd.rd_en  = rd_en;
    assign cmd.clr_en = (state_reg == S_CLEAR);
    assign cmd.addr   = addr_reg;

    assign idle       = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign peak_value = peak_out_reg;
    assign range_low  = low_out_reg;
    assign range_high = high_out_reg;
    assign range_ok   = ok_out_reg;

endmodule

// ===== rtl/histogram_peak_range_picker.sv =====
// Top level of the histogram peak range picker: configuration, input gating and assertions.
//
// The block takes one disparity pixel per cycle while in_ready is high and
// counts those whose column lies in the window crop_col_low..crop_col_high
// into a 256-bin histogram held in a single-port-write, registered-read
// memory; counting is a read-modify-write pipeline with forwarding, so
// same-bin pixels may follow each other back to back. The item marked
// last_of_frame closes the frame: input stays closed while a sequencer sweeps
// the memory one bin per cycle. It searches band 255..201 for the peak, falls
// back to 200..101 and then to 100..51 when the peak is weak against the band
// sum or the band is light against the kept total, then widens the range
// upward and downward from the peak until more than three bins below a tenth
// of the peak count have been passed or bin 255 (upward) or bin 1 (downward)
// is reached. The result is placed in an output register, after which a sweep
// over all 256 bins clears the histogram and the kept count. The pace is set
// by the one memory read port, and in_ready stays low longer while an earlier
// result still waits in the output register. After reset the same clearing
// sweep runs before the first pixel is taken. Configuration writes are taken
// at any time and should be made while idle.
`include "histogram_peak_range_picker_assert.svh"

module histogram_peak_range_picker
    import hppr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COL_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [BIN_BITS-1:0]     pixel_value,
    input  logic [COL_BITS-1:0]     column,
    input  logic                    last_of_frame,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [BIN_BITS-1:0]     peak_value,
    output logic [BIN_BITS-1:0]     range_low,
    output logic [BIN_BITS-1:0]     range_high,
    output logic                    range_ok
);

    logic [COL_BITS-1:0]   crop_col_low_reg;
    logic [COL_BITS-1:0]   crop_col_high_reg;

    logic                  scan_idle;
    logic                  in_accept;
    logic                  in_window;
    logic                  acc_en;
    logic                  frame_end;
    mem_cmd_t              mem_cmd;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] kept_count;

    // Window registers; an empty window (low above high) simply counts nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crop_col_low_reg  <= CROP_COL_LOW_RESET;
            crop_col_high_reg <= CROP_COL_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CROP_COL_LOW:  crop_col_low_reg  <= cfg_data;
                REG_CROP_COL_HIGH: crop_col_high_reg <= cfg_data;
                default:
                begin
                    crop_col_low_reg <= crop_col_low_reg;
                end
            endcase
        end
    end

    // Pixels are taken only while the sequencer is idle, one item per cycle.
    assign in_ready  = scan_idle;
    assign in_accept = in_valid && in_ready;
    assign in_window = (column >= crop_col_low_reg) && (column <= crop_col_high_reg);
    assign acc_en    = in_accept && in_window;
    assign frame_end = in_accept && last_of_frame;

    hppr_hist u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_en     (acc_en),
        .acc_bin    (pixel_value),
        .cmd        (mem_cmd),
        .rd_data    (rd_data),
        .kept_count (kept_count)
    );

    hppr_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (frame_end),
        .rd_data    (rd_data),
        .kept_count (kept_count),
        .cmd        (mem_cmd),
        .idle       (scan_idle),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .peak_value (peak_value),
        .range_low  (range_low),
        .range_high (range_high),
        .range_ok   (range_ok)
    );

    // The frame's last item closes the input on the very next cycle.
    `HPPR_ASSERT_NEXT(a_frame_end_closes, frame_end, !in_ready, "input still open after frame end")
    // The clearing sweep never runs while items can be accepted.
    `HPPR_ASSERT_NOW(a_clear_closed, mem_cmd.clr_en, !in_ready, "clearing while input is open")
    // Sweep reads never take the memory read port from the counting pipeline.
    `HPPR_ASSERT_NOW(a_read_port_owner, in_ready, !mem_cmd.rd_en, "sweep read while input is open")

endmodule

// ===== test/tb_histogram_peak_range_picker.sv =====
// Self-checking testbench for the histogram peak range picker: directed frames, back-pressure and random frames.
module tb_histogram_peak_range_picker;
    import hppr_pkg::*;

    // Run limits; each frame end keeps the block busy while it sweeps the histogram.
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 2500;
    localparam int RANDOM_PIXELS = 540;
    localparam int RANDOM_FRAMES = 25;
    localparam int COL_TOP       = (1 << COL_BITS) - 1;

    // One frame result as the block reports it.
    typedef struct packed {
        logic [BIN_BITS-1:0] peak;
        logic [BIN_BITS-1:0] low;
        logic [BIN_BITS-1:0] high;
        logic                ok;
    } range_pick_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_CROP_COL_LOW;
    logic [COL_BITS-1:0]     cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [BIN_BITS-1:0]     pixel_value = '0;
    logic [COL_BITS-1:0]     column = '0;
    logic                    last_of_frame = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [BIN_BITS-1:0]     peak_value;
    logic [BIN_BITS-1:0]     range_low;
    logic [BIN_BITS-1:0]     range_high;
    logic                    range_ok;

    // Predictor state: its own copy of the histogram, the kept count and the window.
    logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
    logic [COUNT_BITS-1:0] kept_total;
    logic [COL_BITS-1:0]   win_low;
    logic [COL_BITS-1:0]   win_high;

    // Frame results predicted but not yet seen at the output, oldest first.
    range_pick_t expected_picks [$];
    range_pick_t want;

    // Run bookkeeping.
    int failures = 0;
    int cycle_count = 0;
    int pixels_sent = 0;
    int frames_sent = 0;
    int picks_checked = 0;
    int window_settings = 0;

    // Idling controls. The sender side is only used by the stimulus process; the
    // receiver side is read at the clock edge, so it is changed with nonblocking writes.
    bit   pixel_gaps_on = 1'b0;
    logic result_stalls_on = 1'b0;
    logic out_hold = 1'b0;
    int   stall_left = 0;
    event hold_output;

    histogram_peak_range_picker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_value   (pixel_value),
        .column        (column),
        .last_of_frame (last_of_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .peak_value    (peak_value),
        .range_low     (range_low),
        .range_high    (range_high),
        .range_ok      (range_ok)
    );

    // Two time units per period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a run that stalls or loses a result never reaches the final report.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_picks.size());
        $display("FAIL");
        $finish;
    end

    // Long receiver hold-off, counted here so the sender keeps offering items
    // and the block has to fill its output register and close its input.
    always
    begin
        @(hold_output);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
    end

    // Highest count in bins top..bottom, scanning downward so that ties keep the
    // higher bin. With an all-zero band the top bin is returned.
    function automatic logic [BIN_BITS-1:0] band_peak_search(input int top, input int bottom,
                                                             output longint unsigned band_sum);
        longint unsigned best;
        logic [BIN_BITS-1:0] idx;
        best = 0;
        band_sum = 0;
        idx = BIN_BITS'(top);
        for (int b = top; b >= bottom; b--)
        begin
            band_sum += hist_bins[b];
            if (hist_bins[b] > best)
            begin
                best = hist_bins[b];
                idx = BIN_BITS'(b);
            end
        end
        return idx;
    endfunction

    // Counts one accepted pixel and, on the last pixel of a frame, works out the
    // peak and the range, queues the result and clears the histogram.
    task automatic count_pixel(input logic [BIN_BITS-1:0] pix, input logic [COL_BITS-1:0] col,
                               input logic last);
        range_pick_t pick;
        logic [BIN_BITS-1:0] peak;
        longint unsigned band_sum;
        longint unsigned thr;
        int misses;
        if (col >= win_low && col <= win_high)
        begin
            if (hist_bins[pix] != COUNT_MAX)
                hist_bins[pix]++;
            if (kept_total != COUNT_MAX)
                kept_total++;
        end
        if (last)
        begin
            // High band first; a weak peak or a light band falls back to the middle
            // band, and from there to the low band with a looser kept test.
            peak = band_peak_search(255, 201, band_sum);
            if (hist_bins[peak] < band_sum / PEAK_DIV || band_sum < kept_total / KEPT_DIV_HIGH)
            begin
                peak = band_peak_search(200, 101, band_sum);
                if (hist_bins[peak] < band_sum / PEAK_DIV || band_sum < kept_total / KEPT_DIV_MID)
                    peak = band_peak_search(100, 51, band_sum);
            end
            thr = hist_bins[peak] / THR_DIV;
            pick.peak = peak;
            pick.low = peak;
            pick.high = peak;
            // Widen upward to bin 255, then downward to bin 1; bin 0 is never looked at.
            misses = 0;
            for (int b = int'(peak); b <= int'(UP_END) && misses <= MISS_LIMIT; b++)
            begin
                if (hist_bins[b] < thr)
                    misses++;
                else
                    pick.high = BIN_BITS'(b);
            end
            misses = 0;
            for (int b = int'(peak); b >= int'(DOWN_END) && misses <= MISS_LIMIT; b--)
            begin
                if (hist_bins[b] < thr)
                    misses++;
                else
                    pick.low = BIN_BITS'(b);
            end
            pick.ok = (pick.high != pick.low) && (pick.high != pick.peak);
            expected_picks.insert(expected_picks.size(), pick);
            foreach (hist_bins[b])
                hist_bins[b] = '0;
            kept_total = '0;
        end
    endtask

    // Offers one pixel and waits until it is taken. Valid is left high on return
    // so that the next item follows without a bubble, unless a gap is drawn.
    task automatic send_pixel(input logic [BIN_BITS-1:0] pix, input logic [COL_BITS-1:0] col,
                              input logic last);
        in_valid <= 1'b1;
        pixel_value <= pix;
        column <= col;
        last_of_frame <= last;
        do
            @(posedge clk);
        while (!in_ready);
        count_pixel(pix, col, last);
        pixels_sent++;
        if (last)
            frames_sent++;
        if (pixel_gaps_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Closes the input and waits until every predicted result has been checked,
    // then lets the clearing sweep after the last frame finish.
    task automatic wait_for_picks();
        in_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both window registers, one per cycle. Only called with the block idle.
    task automatic set_window(input logic [COL_BITS-1:0] first_col,
                              input logic [COL_BITS-1:0] last_col);
        cfg_write <= 1'b1;
        cfg_index <= REG_CROP_COL_LOW;
        cfg_data <= first_col;
        @(posedge clk);
        cfg_index <= REG_CROP_COL_HIGH;
        cfg_data <= last_col;
        @(posedge clk);
        cfg_write <= 1'b0;
        win_low = first_col;
        win_high = last_col;
        window_settings++;
    endtask

    // One random frame. Four in ten frames cluster around a disparity, mostly in
    // one of the bands, so the peak has enough weight for the range search to stop
    // on weak bins; others are sparse noise, mostly-near frames that force the band
    // fallbacks, and flat frames whose peak is weak against the band sum.
    task automatic send_random_frame();
        int kind;
        int len;
        int center;
        int spread;
        int p;
        int r;
        logic [COL_BITS-1:0] col;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: center = $urandom_range(201, 255);
            1: center = $urandom_range(101, 200);
            2: center = $urandom_range(51, 100);
            default: center = $urandom_range(0, 255);
        endcase
        spread = $urandom_range(1, 12);
        if (kind < 4)
            len = $urandom_range(12, 40);
        else if (kind < 7)
            len = $urandom_range(1, 10);
        else if (kind < 9)
            len = $urandom_range(5, 25);
        else
            len = $urandom_range(42, 55);
        for (int n = 0; n < len; n++)
        begin
            r = $urandom_range(0, 99);
            if (kind < 4)
            begin
                if (r < 50)
                    p = center;
                else if (r < 90)
                    p = center + $urandom_range(0, 2 * spread) - spread;
                else
                    p = $urandom_range(0, 255);
            end
            else if (kind < 7)
                p = $urandom_range(0, 255);
            else if (kind < 9)
                p = (r < 70) ? $urandom_range(0, 50) : center + $urandom_range(0, 2 * spread) - spread;
            else
                p = (center > 150) ? 255 - n : 200 - n;
            if (p < 0)
                p = 0;
            if (p > 255)
                p = 255;
            if (win_low <= win_high && $urandom_range(0, 99) < 85)
                col = COL_BITS'($urandom_range(win_low, win_high));
            else
                col = COL_BITS'($urandom_range(0, COL_TOP));
            send_pixel(BIN_BITS'(p), col, n == len - 1);
        end
    endtask

    // Reset window 150..489: the columns on both sides of each edge, bins 0 and
    // 255, then a frame whose only pixel falls outside, which leaves an empty
    // histogram (peak 255, range 1..255).
    task automatic test_default_window();
        send_pixel(8'd255, 11'd150, 1'b0);
        send_pixel(8'd0, 11'd489, 1'b0);
        send_pixel(8'd7, 11'd149, 1'b0);
        send_pixel(8'd9, 11'd490, 1'b0);
        send_pixel(8'd255, 11'd300, 1'b1);
        send_pixel(8'd100, 11'd0, 1'b1);
        wait_for_picks();
    endtask

    // Window at its widest, empty (first column above last) and one column wide.
    task automatic test_window_extremes();
        set_window(11'd0, 11'(COL_TOP));
        send_pixel(8'd0, 11'd0, 1'b0);
        send_pixel(8'd255, 11'(COL_TOP), 1'b0);
        send_pixel(8'd128, 11'd1024, 1'b1);
        wait_for_picks();
        set_window(11'(COL_TOP), 11'd0);
        send_pixel(8'd200, 11'd1024, 1'b0);
        send_pixel(8'd7, 11'd0, 1'b1);
        wait_for_picks();
        set_window(11'd5, 11'd5);
        send_pixel(8'd210, 11'd4, 1'b0);
        send_pixel(8'd210, 11'd5, 1'b0);
        send_pixel(8'd220, 11'd6, 1'b1);
        wait_for_picks();
    endtask

    // A lone high-band pixel against twenty pixels in bin 0 is too light for the
    // high band, the empty middle band is too light as well, so the low band wins.
    // Then a tie between bins 240 and 220, which goes to the higher bin.
    task automatic test_band_fallback();
        set_window(11'd0, 11'(COL_TOP));
        send_pixel(8'd210, 11'd10, 1'b0);
        send_pixel(8'd60, 11'd11, 1'b0);
        for (int n = 0; n < 20; n++)
            send_pixel(8'd0, 11'(n * 97), n == 19);
        send_pixel(8'd240, 11'd3, 1'b0);
        send_pixel(8'd220, 11'd4, 1'b0);
        send_pixel(8'd240, 11'd5, 1'b0);
        send_pixel(8'd220, 11'd6, 1'b1);
        wait_for_picks();
    endtask

    // The receiver holds off for a long time while several frames are offered,
    // so the finished result waits in the block and its input must close.
    task automatic test_output_hold();
        -> hold_output;
        for (int f = 0; f < 4; f++)
            send_random_frame();
        wait_for_picks();
    endtask

    // Random frames in phases, each phase under its own window. Idling is drawn
    // per phase so that some stretches run without gaps; the last quarter runs
    // with none at all.
    task automatic test_random_frames();
        int phase;
        int start_pixels;
        int start_frames;
        int lo;
        int hi;
        phase = 0;
        start_pixels = pixels_sent;
        start_frames = frames_sent;
        while (pixels_sent - start_pixels < RANDOM_PIXELS || frames_sent - start_frames < RANDOM_FRAMES)
        begin
            case (phase % 6)
                0: begin lo = 0; hi = COL_TOP; end
                1: begin lo = 150; hi = 489; end
                2: begin lo = $urandom_range(0, COL_TOP); hi = lo; end
                3: begin lo = $urandom_range(1, COL_TOP); hi = $urandom_range(0, lo - 1); end
                4: begin lo = $urandom_range(0, 1000); hi = $urandom_range(lo, COL_TOP); end
                default: begin lo = $urandom_range(0, COL_TOP); hi = $urandom_range(0, COL_TOP); end
            endcase
            set_window(COL_BITS'(lo), COL_BITS'(hi));
            if (pixels_sent - start_pixels < RANDOM_PIXELS * 3 / 4)
            begin
                pixel_gaps_on = ($urandom_range(0, 2) != 0);
                result_stalls_on <= ($urandom_range(0, 2) != 0);
            end
            else
            begin
                pixel_gaps_on = 1'b0;
                result_stalls_on <= 1'b0;
            end
            repeat ($urandom_range(5, 8))
                send_random_frame();
            wait_for_picks();
            phase++;
        end
    endtask

    // Result checker and receiver. Every taken result is compared field by field
    // with the oldest prediction; ready then drops for random stalls and for the
    // long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_picks.size() == 0)
                begin
                    $display("%0t: result with none expected: peak %0d range %0d..%0d ok %0d",
                             $time, peak_value, range_low, range_high, range_ok);
                    failures++;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    picks_checked++;
                    if (peak_value !== want.peak)
                    begin
                        $display("%0t: peak_value expected %0d got %0d", $time, want.peak, peak_value);
                        failures++;
                    end
                    if (range_low !== want.low)
                    begin
                        $display("%0t: range_low expected %0d got %0d", $time, want.low, range_low);
                        failures++;
                    end
                    if (range_high !== want.high)
                    begin
                        $display("%0t: range_high expected %0d got %0d", $time, want.high, range_high);
                        failures++;
                    end
                    if (range_ok !== want.ok)
                    begin
                        $display("%0t: range_ok expected %0d got %0d", $time, want.ok, range_ok);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (result_stalls_on && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 17);
            out_ready <= (stall_left == 0) && !out_hold;
        end
    end

    // Reset once, run the tests in turn, then report.
    initial
    begin
        foreach (hist_bins[b])
            hist_bins[b] = '0;
        kept_total = '0;
        win_low = CROP_COL_LOW_RESET;
        win_high = CROP_COL_HIGH_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pixel_gaps_on = 1'b1;
        result_stalls_on <= 1'b1;
        test_default_window();
        test_window_extremes();
        test_band_fallback();
        test_output_hold();
        test_random_frames();

        if (expected_picks.size() != 0)
        begin
            $display("%0d predicted results never arrived", expected_picks.size());
            failures++;
        end
        $display("Sent %0d pixels in %0d frames under %0d window settings; %0d results checked.",
                 pixels_sent, frames_sent, window_settings, picks_checked);
        $display("Included band fallbacks, empty and one-column windows, a long output hold-off and %0d cycles.",
                 cycle_count);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
